// ----- rtl/core/itp_pkg.sv -----
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_TERM  = 8'h00;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_CLOSE    = 2'd2;
    localparam logic [1:0] ST_OPEN     = 2'd3;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_PLUS  = 3'd1,
        OP_MINUS = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4
    } op_code_t;

    // Per-cell command: keep, take the neighbor nearer the top, or the one below.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_ABOVE,
        CELL_LOAD_BELOW
    } cell_cmd_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_REPLACE
    } stack_cmd_t;

    typedef struct packed {
        stack_cmd_t cmd;
        op_code_t   code;
    } stack_ctl_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_expression;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] ch;
        unique case (code)
            OP_OPEN:  ch = CH_OPEN;
            OP_PLUS:  ch = CH_PLUS;
            OP_MINUS: ch = CH_MINUS;
            OP_MUL:   ch = CH_MUL;
            OP_DIV:   ch = CH_DIV;
            default:  ch = CH_TERM;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/itp_cell.sv -----
module itp_cell import itp_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  op_code_t  above,
    input  op_code_t  below,
    output op_code_t  q
);

    op_code_t q_reg;

    always_ff @(posedge aclk) begin
        unique case (cmd)
            CELL_HOLD:       q_reg <= q_reg;
            CELL_LOAD_ABOVE: q_reg <= above;
            CELL_LOAD_BELOW: q_reg <= below;
            default:         q_reg <= q_reg;
        endcase
    end

    assign q = q_reg;

endmodule

// ----- rtl/core/itp_stack.sv -----
module itp_stack import itp_pkg::*; (
    input  logic       aclk,
    input  stack_ctl_t ctl,
    output op_code_t   top
);

    op_code_t  cell_q     [STACK_DEPTH];
    op_code_t  cell_above [STACK_DEPTH];
    op_code_t  cell_below [STACK_DEPTH];
    cell_cmd_t cell_cmd   [STACK_DEPTH];

    // Cell 0 is the top of the stack. A push shifts every entry one cell
    // deeper, a pop shifts every entry one cell up, and a replace rewrites
    // only the top cell.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign cell_above[i] = ctl.code;
        end else begin : g_inner
            assign cell_above[i] = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign cell_below[i] = OP_OPEN;
        end else begin : g_notlast
            assign cell_below[i] = cell_q[i+1];
        end

        always_comb begin
            unique case (ctl.cmd)
                STK_HOLD:    cell_cmd[i] = CELL_HOLD;
                STK_PUSH:    cell_cmd[i] = CELL_LOAD_ABOVE;
                STK_POP:     cell_cmd[i] = CELL_LOAD_BELOW;
                STK_REPLACE: cell_cmd[i] = (i == 0) ? CELL_LOAD_ABOVE : CELL_HOLD;
                default:     cell_cmd[i] = CELL_HOLD;
            endcase
        end

        itp_cell u_cell (
            .aclk  (aclk),
            .cmd   (cell_cmd[i]),
            .above (cell_above[i]),
            .below (cell_below[i]),
            .q     (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Channel   Direction  Ports                        Payload
// s_        input      s_valid, s_ready, s_data     in_item_t  (char_in, end_of_expression)
// m_        output     m_valid, m_ready, m_data     out_item_t (char_out, last, status)
//
// An item is taken in the idle state and worked on in the execute state, which
// pops one operator per step; no new item is taken until it is done. An end item
// then flushes every remaining stack entry and emits the terminator.
// The operator stack is a row of cells shifted one entry per cycle, so pops are emitted
// one per cycle through the single output register while the output is not stalled.
// Reset clears the sequencer, the stack count, the status and the output
// valid; the stack cells themselves are not reset.
// A stalled output holds the sequencer wherever it must emit a character.
module infix_to_postfix_converter import itp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] err_reg, err_next;
    in_item_t   cur_reg, cur_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    stack_ctl_t stk_ctl;
    op_code_t   top;
    logic       out_free;
    logic       emit;
    out_item_t  emit_item;
    logic       emit_term;
    logic       done;
    logic       push_req;
    op_code_t   push_code;
    op_code_t   md_code;
    logic       stack_empty;

    itp_stack u_stack (
        .aclk (aclk),
        .ctl  (stk_ctl),
        .top  (top)
    );

    assign out_free    = !m_valid_reg || m_ready;
    assign stack_empty = (cnt_reg == '0);
    assign md_code     = (cur_reg.char_in == CH_MUL) ? OP_MUL : OP_DIV;
    assign push_code   = (cur_reg.char_in == CH_OPEN)  ? OP_OPEN  :
                         (cur_reg.char_in == CH_PLUS)  ? OP_PLUS  :
                         (cur_reg.char_in == CH_MINUS) ? OP_MINUS : md_code;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        cur_next     = cur_reg;
        stk_ctl.cmd  = STK_HOLD;
        stk_ctl.code = OP_OPEN;
        emit         = 1'b0;
        emit_item    = '0;
        emit_term    = 1'b0;
        done         = 1'b0;
        push_req     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cur_next   = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (cur_reg.char_in)
                    CH_OPEN: begin
                        push_req = 1'b1;
                        done     = 1'b1;
                    end
                    CH_MUL, CH_DIV: begin
                        if (!stack_empty && (top == OP_MUL || top == OP_DIV)) begin
                            // Pop and push at once: the new operator takes the top cell.
                            if (out_free) begin
                                emit               = 1'b1;
                                emit_item.char_out = op_char(top);
                                stk_ctl.cmd        = STK_REPLACE;
                                stk_ctl.code       = md_code;
                                done               = 1'b1;
                            end
                        end else begin
                            push_req = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    CH_PLUS, CH_MINUS, CH_CLOSE: begin
                        if (!stack_empty && top != OP_OPEN) begin
                            if (out_free) begin
                                emit               = 1'b1;
                                emit_item.char_out = op_char(top);
                                stk_ctl.cmd        = STK_POP;
                                cnt_next           = cnt_reg - 1'b1;
                            end
                        end else if (cur_reg.char_in != CH_CLOSE) begin
                            push_req = 1'b1;
                            done     = 1'b1;
                        end else if (!stack_empty) begin
                            // Drop the matching opening parenthesis.
                            stk_ctl.cmd = STK_POP;
                            cnt_next    = cnt_reg - 1'b1;
                            done        = 1'b1;
                        end else begin
                            if (err_reg == ST_OK) begin
                                err_next = ST_CLOSE;
                            end
                            done = 1'b1;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit               = 1'b1;
                            emit_item.char_out = cur_reg.char_in;
                            done               = 1'b1;
                        end
                    end
                endcase

                if (push_req) begin
                    if (cnt_reg >= CNT_W'(STACK_DEPTH)) begin
                        if (err_reg == ST_OK) begin
                            err_next = ST_OVERFLOW;
                        end
                    end else begin
                        stk_ctl.cmd  = STK_PUSH;
                        stk_ctl.code = push_code;
                        cnt_next     = cnt_reg + 1'b1;
                    end
                end

                if (done) begin
                    state_next = cur_reg.end_of_expression ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!stack_empty) begin
                    if (top == OP_OPEN) begin
                        if (err_reg == ST_OK) begin
                            err_next = ST_OPEN;
                        end
                        stk_ctl.cmd = STK_POP;
                        cnt_next    = cnt_reg - 1'b1;
                    end else if (out_free) begin
                        emit               = 1'b1;
                        emit_item.char_out = op_char(top);
                        stk_ctl.cmd        = STK_POP;
                        cnt_next           = cnt_reg - 1'b1;
                    end
                end else if (out_free) begin
                    emit               = 1'b1;
                    emit_term          = 1'b1;
                    emit_item.char_out = CH_TERM;
                    emit_item.last     = 1'b1;
                    emit_item.status   = err_reg;
                    err_next           = ST_OK;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_data_next = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond the stack depth");

    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last || m_data_reg.status == ST_OK))
        else $error("error status on a character that is not the terminator");

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_term |=> (cnt_reg == '0 && err_reg == ST_OK && state_reg == S_IDLE))
        else $error("state not clean after the terminator");

    a_first_error_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK && !emit_term) |=> (err_reg == $past(err_reg)))
        else $error("recorded error overwritten before the terminator");

endmodule

// ----- verif/itp_checker.sv -----
module itp_checker import itp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int unsigned mismatch_count,
    output int unsigned results_due
);

    op_code_t    op_stack [STACK_DEPTH];
    int unsigned stack_used;
    logic [1:0]  expr_status;
    out_item_t   postfix_due [$];

    function automatic logic [IDX_W-1:0] top_idx();
        return IDX_W'(stack_used - 1);
    endfunction

    task automatic emit_postfix(input logic [7:0] ch, input logic fin, input logic [1:0] st);
        out_item_t item;
        item.char_out = ch;
        item.last     = fin;
        item.status   = st;
        postfix_due.push_back(item);
    endtask

    // Only the first error of an expression is reported on its terminator.
    task automatic keep_first_error(input logic [1:0] code);
        if (expr_status == ST_OK) begin
            expr_status = code;
        end
    endtask

    task automatic push_operator(input op_code_t code);
        if (stack_used >= STACK_DEPTH) begin
            keep_first_error(ST_OVERFLOW);
        end else begin
            op_stack[IDX_W'(stack_used)] = code;
            stack_used++;
        end
    endtask

    // An opening parenthesis leaves the stack without producing a character.
    task automatic pop_operator();
        op_code_t code;
        code = op_stack[top_idx()];
        stack_used--;
        case (code)
            OP_PLUS:  emit_postfix(CH_PLUS, 1'b0, ST_OK);
            OP_MINUS: emit_postfix(CH_MINUS, 1'b0, ST_OK);
            OP_MUL:   emit_postfix(CH_MUL, 1'b0, ST_OK);
            OP_DIV:   emit_postfix(CH_DIV, 1'b0, ST_OK);
            default:  ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input bit have_want,
                                   input out_item_t want, input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (have_want) begin
                $display("%s: expected char %02h last %0b status %0d, got char %02h last %0b status %0d",
                         what, want.char_out, want.last, want.status,
                         got.char_out, got.last, got.status);
            end else begin
                $display("%s: expected nothing, got char %02h last %0b status %0d",
                         what, got.char_out, got.last, got.status);
            end
        end
    endtask

    always @(posedge aclk) begin : check_proc
        out_item_t  want;
        logic [7:0] ch;
        if (!aresetn) begin
            postfix_due.delete();
            stack_used     = 0;
            expr_status    = ST_OK;
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                ch = s_data.char_in;
                case (ch)
                    CH_OPEN: begin
                        push_operator(OP_OPEN);
                    end
                    CH_MUL, CH_DIV: begin
                        if (stack_used > 0 && (op_stack[top_idx()] == OP_MUL ||
                                               op_stack[top_idx()] == OP_DIV)) begin
                            pop_operator();
                        end
                        push_operator(ch == CH_MUL ? OP_MUL : OP_DIV);
                    end
                    CH_PLUS, CH_MINUS: begin
                        while (stack_used > 0 && op_stack[top_idx()] != OP_OPEN) begin
                            pop_operator();
                        end
                        push_operator(ch == CH_PLUS ? OP_PLUS : OP_MINUS);
                    end
                    CH_CLOSE: begin
                        while (stack_used > 0 && op_stack[top_idx()] != OP_OPEN) begin
                            pop_operator();
                        end
                        if (stack_used > 0) begin
                            stack_used--;
                        end else begin
                            keep_first_error(ST_CLOSE);
                        end
                    end
                    default: begin
                        emit_postfix(ch, 1'b0, ST_OK);
                    end
                endcase
                if (s_data.end_of_expression) begin
                    while (stack_used > 0) begin
                        if (op_stack[top_idx()] == OP_OPEN) begin
                            keep_first_error(ST_OPEN);
                        end
                        pop_operator();
                    end
                    emit_postfix(CH_TERM, 1'b1, expr_status);
                    expr_status = ST_OK;
                end
            end
            if (m_valid && m_ready) begin
                if (postfix_due.size() == 0) begin
                    want = '0;
                    report_mismatch("Unexpected result transfer", 1'b0, want, m_data);
                end else begin
                    want = postfix_due.pop_front();
                    if (m_data.char_out !== want.char_out || m_data.last !== want.last ||
                        m_data.status !== want.status) begin
                        report_mismatch("Result mismatch", 1'b1, want, m_data);
                    end
                end
            end
        end
        results_due = postfix_due.size();
    end

endmodule

// ----- verif/tb_infix_to_postfix_converter.sv -----
module tb_infix_to_postfix_converter;
    import itp_pkg::*;

    localparam int RANDOM_ITEMS   = 270;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    int unsigned mismatch_count;
    int unsigned results_due;
    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 67;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;

    infix_to_postfix_converter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    itp_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [7:0] ch, input logic eoe);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid                  = 1'b1;
        s_data.char_in           = ch;
        s_data.end_of_expression = eoe;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input logic eoe_at_end);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_item(txt[i], eoe_at_end && (i == txt.len() - 1));
        end
    endtask

    task automatic wait_for_postfix_drain();
        s_valid = 1'b0;
        while (results_due != 0) begin
            @(negedge aclk);
        end
    endtask

    // The first four choices are the binary operators, the last two the parentheses.
    function automatic logic [7:0] pick_operator(input int unsigned choices);
        logic [7:0] ch;
        case ($urandom_range(choices - 1))
            0:       ch = CH_PLUS;
            1:       ch = CH_MINUS;
            2:       ch = CH_MUL;
            3:       ch = CH_DIV;
            4:       ch = CH_OPEN;
            default: ch = CH_CLOSE;
        endcase
        return ch;
    endfunction

    initial begin
        logic [7:0]  expr_chars [$];
        logic [7:0]  c;
        int unsigned phase;
        int unsigned random_end;
        int          open_cnt;
        int          max_open;
        int          terms;
        int          mode;
        int          pos;
        int          t;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Operand extremes, every operator, equal-precedence pops and a space.
        send_item(8'h00, 1'b0);
        send_text("*b/c*d -e+", 1'b0);
        send_item(8'hFF, 1'b1);
        // A full stack drops the next operator; the open left behind is a second error.
        repeat (STACK_DEPTH) send_item(CH_OPEN, 1'b0);
        send_item(CH_MUL, 1'b0);
        send_item(CH_CLOSE, 1'b1);
        // A close with no open still flushes what is on the stack.
        send_text("+)", 1'b1);
        send_item(CH_OPEN, 1'b1);
        wait_for_postfix_drain();

        random_end = items_sent;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_end += RANDOM_ITEMS / 3;
            while (items_sent < random_end) begin
                expr_chars.delete();
                mode = $urandom_range(99);
                if (mode < 12) begin
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(1)) begin
                            c = 8'($urandom_range(255));
                        end else begin
                            c = pick_operator(6);
                        end
                        expr_chars.push_back(c);
                    end
                end else begin
                    open_cnt = 0;
                    terms    = $urandom_range(1, 6);
                    if ($urandom_range(9) == 0) begin
                        // Deep nesting runs the stack up to and past its limit.
                        max_open = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
                        repeat (max_open) expr_chars.push_back(CH_OPEN);
                        open_cnt = max_open;
                    end else begin
                        max_open = $urandom_range(0, 3);
                    end
                    for (t = 0; t < terms; t++) begin
                        while (open_cnt < max_open && $urandom_range(2) == 0) begin
                            expr_chars.push_back(CH_OPEN);
                            open_cnt++;
                        end
                        do begin
                            c = 8'($urandom_range(255));
                        end while (c == CH_OPEN || c == CH_CLOSE || c == CH_MUL ||
                                   c == CH_DIV || c == CH_PLUS || c == CH_MINUS);
                        expr_chars.push_back(c);
                        if ($urandom_range(6) == 0) begin
                            expr_chars.push_back(8'h20);
                        end
                        while (open_cnt > 0 && $urandom_range(2) == 0) begin
                            expr_chars.push_back(CH_CLOSE);
                            open_cnt--;
                        end
                        if (t < terms - 1) begin
                            expr_chars.push_back(pick_operator(4));
                        end
                    end
                    while (open_cnt > 0) begin
                        expr_chars.push_back(CH_CLOSE);
                        open_cnt--;
                    end
                    if (mode < 27) begin
                        pos = $urandom_range(expr_chars.size() - 1);
                        if ($urandom_range(1)) begin
                            expr_chars.delete(pos);
                        end else begin
                            expr_chars.insert(pos, pick_operator(6));
                        end
                        if (expr_chars.size() == 0) begin
                            expr_chars.push_back(pick_operator(6));
                        end
                    end
                end
                for (t = 0; t < expr_chars.size(); t++) begin
                    send_item(expr_chars[t], t == expr_chars.size() - 1);
                end
            end
            wait_for_postfix_drain();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
